[src/shared_pool_multi_stack_core_assert.svh]
// Assertion macros used by the checker module of the multi-stack core.
`ifndef SHARED_POOL_MULTI_STACK_CORE_ASSERT_SVH
`define SHARED_POOL_MULTI_STACK_CORE_ASSERT_SVH

// Overlapping implication, sampled on clk and disabled while rst_n is low.
`define SPMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spms assertion failed");

// Implication checked in the cycle after the antecedent.
`define SPMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spms assertion failed");

`endif

[src/spms_pkg.sv]
// Package with sizes, codes and shared types of the multi-stack core.
package spms_pkg;

  localparam int NUM_STACKS = 4;
  localparam int POOL_SLOTS = 16;

  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int PTR_W  = $clog2(POOL_SLOTS + 1);
  localparam int TOPS_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SID_W  = 2;
  localparam int DATA_W = 32;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t NULL_PTR = PTR_W'(POOL_SLOTS);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

[src/shared_pool_multi_stack_core.sv]
// Top level of the shared-pool multi-stack core.
// Four stacks share a pool of sixteen slots chained by a link memory and a
// free list. Each transfer in has a read step and a write-back step: the first
// reads the link and value memories at the slot picked by the free-list head
// or the stack top, the second updates the links, the tops and the free-list
// head and loads the result register. A new item is taken the cycle after that
// write-back, so the core takes no new item while one is in flight; a result
// not yet taken holds the write-back step until the output register frees.
// Reset is ready at once: link entries carry valid bits, no clearing pass is run.
module shared_pool_multi_stack_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [spms_pkg::SID_W-1:0]           in_stack_id,
  input  logic signed [spms_pkg::DATA_W-1:0]   in_push_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic signed [spms_pkg::DATA_W-1:0]   out_pop_value
);
  import spms_pkg::*;

  cmd_t cmd;

  spms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spms_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_stack_id   (in_stack_id),
    .in_push_value (in_push_value),
    .out_status    (out_status),
    .out_pop_value (out_pop_value)
  );

endmodule

[src/spms_ctrl.sv]
// Controller state machine: handshakes and load/commit sequencing.
module spms_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spms_pkg::cmd_t cmd
);
  import spms_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/spms_dpath.sv]
// Datapath: slot memories, stack tops, free-list head and result register.
module spms_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spms_pkg::cmd_t                       cmd,
  input  logic                                 in_action,
  input  logic [spms_pkg::SID_W-1:0]           in_stack_id,
  input  logic signed [spms_pkg::DATA_W-1:0]   in_push_value,
  output logic [1:0]                           out_status,
  output logic signed [spms_pkg::DATA_W-1:0]   out_pop_value
);
  import spms_pkg::*;

  logic [DATA_W-1:0] values_mem [POOL_SLOTS];
  ptr_t              links_mem  [POOL_SLOTS];

  logic [POOL_SLOTS-1:0] lvalid_r, lvalid_nxt;
  ptr_t                  tops_r [NUM_STACKS];
  ptr_t                  tops_nxt [NUM_STACKS];
  ptr_t                  free_head_r, free_head_nxt;

  logic              op_r;
  logic [TOPS_W-1:0] sid_r;
  logic              sid_ok_r;
  logic [DATA_W-1:0] val_r;
  ptr_t              slot_r;
  ptr_t              link_rd_r;
  logic              lval_rd_r;
  logic [DATA_W-1:0] value_rd_r;
  logic [1:0]        status_r;
  logic [DATA_W-1:0] pop_value_r;

  logic              sid_ok;
  logic [TOPS_W-1:0] sidx;
  ptr_t              slot_sel;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  ptr_t              link_eff;
  logic              slot_ok;
  logic              push_ok;
  logic              pop_ok;
  logic              link_we;
  ptr_t              link_wd;

  assign sid_ok = (32'(in_stack_id) < NUM_STACKS);
  assign sidx   = TOPS_W'(in_stack_id);

  always_comb begin
    if (in_action == ACT_PUSH) begin
      slot_sel = free_head_r;
    end else if (sid_ok) begin
      slot_sel = tops_r[sidx];
    end else begin
      slot_sel = NULL_PTR;
    end
  end

  assign rd_addr = slot_sel[SLOT_W-1:0];
  assign wr_addr = slot_r[SLOT_W-1:0];

  // A link entry never written since reset reads as its reset chain value, slot plus one.
  assign link_eff = lval_rd_r ? link_rd_r : ptr_t'(slot_r + ptr_t'(1));
  assign slot_ok  = (slot_r != NULL_PTR);
  assign push_ok  = (op_r == ACT_PUSH) && sid_ok_r && slot_ok;
  assign pop_ok   = (op_r == ACT_POP) && slot_ok;
  assign link_we  = cmd.commit && (push_ok || pop_ok);
  assign link_wd  = push_ok ? tops_r[sid_r] : free_head_r;

  always_comb begin
    lvalid_nxt    = lvalid_r;
    tops_nxt      = tops_r;
    free_head_nxt = free_head_r;
    if (link_we) begin
      lvalid_nxt[wr_addr] = 1'b1;
      if (push_ok) begin
        tops_nxt[sid_r] = slot_r;
        free_head_nxt   = link_eff;
      end else begin
        tops_nxt[sid_r] = link_eff;
        free_head_nxt   = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r    <= '0;
      free_head_r <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_r[i] <= NULL_PTR;
      end
    end else begin
      lvalid_r    <= lvalid_nxt;
      free_head_r <= free_head_nxt;
      tops_r      <= tops_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_action;
      sid_r      <= sidx;
      sid_ok_r   <= sid_ok;
      val_r      <= in_push_value;
      slot_r     <= slot_sel;
      link_rd_r  <= links_mem[rd_addr];
      lval_rd_r  <= lvalid_r[rd_addr];
      value_rd_r <= values_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      links_mem[wr_addr] <= link_wd;
    end
    if (cmd.commit && push_ok) begin
      values_mem[wr_addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_r == ACT_PUSH) begin
        status_r <= push_ok ? ST_OK : ST_FULL;
      end else begin
        status_r <= pop_ok ? ST_OK : ST_EMPTY;
      end
      pop_value_r <= pop_ok ? value_rd_r : '0;
    end
  end

  assign out_status    = status_r;
  assign out_pop_value = pop_value_r;

endmodule

[src/spms_chk.sv]
// Port-level checker for the multi-stack core and its bind statement.
`include "shared_pool_multi_stack_core_assert.svh"

module spms_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_status,
  input logic signed [spms_pkg::DATA_W-1:0] out_pop_value
);
  import spms_pkg::*;

  `SPMS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `SPMS_ASSERT_NEXT(a_idle_stays_ready, in_ready && !in_valid, in_ready)
  `SPMS_ASSERT_SAME(a_refused_is_zero, out_valid && out_status != ST_OK, out_pop_value == '0)
  `SPMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_pop_value))

endmodule

bind shared_pool_multi_stack_core spms_chk u_spms_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_pop_value (out_pop_value)
);
